### rtl/vtpd_pkg.sv
`timescale 1ns / 1ps
package vtpd_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_REGS = 8;
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;
	localparam int ENTRY_W = 32;
	localparam int NUM_ENTRIES = 16;
	localparam int ACC_W = 66;
	localparam int MAG_W = 65;
	localparam int DIV_STEPS = 32;
	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES = DIV_STEPS / STEPS_PER_STAGE;
	localparam int LANES = 3;

	typedef logic [NUM_ENTRIES-1:0][ENTRY_W-1:0] matrix_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               w_was_zero;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [MAG_W-1:0] rem;
		logic [31:0]      low;
	} div_in_t;

	typedef struct packed {
		logic [31:0] val;
		logic        clamp;
	} sat_t;

	function automatic sat_t sat32(input logic neg, input logic [MAG_W-1:0] mag);
		sat_t s;
		if (!neg) begin
			if (mag > MAG_W'(33'h0_7FFF_FFFF)) begin
				s.val = 32'h7FFF_FFFF;
				s.clamp = 1'b1;
			end else begin
				s.val = mag[31:0];
				s.clamp = 1'b0;
			end
		end else if (mag > MAG_W'(33'h0_8000_0000)) begin
			s.val = 32'h8000_0000;
			s.clamp = 1'b1;
		end else begin
			s.val = ~mag[31:0] + 32'd1;
			s.clamp = 1'b0;
		end
		return s;
	endfunction
endpackage

### rtl/vtpd_cfg.sv
`timescale 1ns / 1ps
module vtpd_cfg #(
	parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vtpd_pkg::ADDR_W-1:0] paddr,
	input  logic [vtpd_pkg::DATA_W-1:0] pwdata,
	output logic [vtpd_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output vtpd_pkg::matrix_t           matrix
);
	import vtpd_pkg::*;

	localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

	logic [DATA_W-1:0] regs_q [NUM_REGS];
	logic [2:0]        idx;

	assign idx = paddr[ADDR_W-1:3];
	assign pready = 1'b1;
	assign prdata = regs_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_REGS; k++) regs_q[k] <= '0;
			regs_q[0] <= {32'd0, ONE};
			regs_q[2] <= {ONE, 32'd0};
			regs_q[5] <= {32'd0, ONE};
			regs_q[7] <= {ONE, 32'd0};
		end else if (psel && penable && pwrite && pready) begin
			regs_q[idx] <= pwdata;
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_REGS; k++) begin
			matrix[2*k]   = regs_q[k][31:0];
			matrix[2*k+1] = regs_q[k][63:32];
		end
	end
endmodule

### rtl/vtpd_mac.sv
`timescale 1ns / 1ps
module vtpd_mac #(
	parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  vtpd_pkg::point_t           point,
	input  vtpd_pkg::matrix_t          matrix,
	output logic                       valid_s3,
	output vtpd_pkg::div_in_t          lane_s3 [vtpd_pkg::LANES],
	output vtpd_pkg::sat_t             zres_s3 [vtpd_pkg::LANES],
	output logic [vtpd_pkg::MAG_W-1:0] wmag_s3,
	output logic                       wzero_s3
);
	import vtpd_pkg::*;

	localparam int NUM_W = MAG_W + FRAC_BITS;
	localparam int HI_W = NUM_W - 32;

	logic signed [31:0]    pt [LANES];
	logic signed [63:0]    prod_s1 [4][LANES];
	logic signed [ACC_W-1:0] trans_s1 [4];
	logic signed [ACC_W-1:0] sum_s2 [4];
	logic                  valid_s1, valid_s2;

	logic [MAG_W-1:0] mag [4];
	logic             neg [4];
	logic [NUM_W-1:0] num [LANES];
	logic [HI_W-1:0]  hi [LANES];

	assign pt[0] = point.point_x;
	assign pt[1] = point.point_y;
	assign pt[2] = point.point_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: the twelve products and the translation column.
	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < LANES; c++)
				prod_s1[r][c] <= pt[c] * $signed(matrix[c*4+r]);
			trans_s1[r] <= ACC_W'($signed(matrix[12+r])) <<< FRAC_BITS;
		end
	end

	// Stage 2: exact row sums.
	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++)
			sum_s2[r] <= ACC_W'(prod_s1[r][0]) + ACC_W'(prod_s1[r][1])
				+ ACC_W'(prod_s1[r][2]) + trans_s1[r];
	end

	// Stage 3: sign and magnitude, divider set-up and the undivided path.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			neg[r] = sum_s2[r][ACC_W-1];
			mag[r] = neg[r] ? MAG_W'(-sum_s2[r]) : MAG_W'(sum_s2[r]);
		end
		for (int c = 0; c < LANES; c++) begin
			num[c] = {mag[c], {FRAC_BITS{1'b0}}};
			hi[c] = num[c][NUM_W-1:32];
		end
	end

	always_ff @(posedge clk) begin
		wmag_s3 <= mag[3];
		wzero_s3 <= (sum_s2[3] == '0);
		for (int c = 0; c < LANES; c++) begin
			lane_s3[c].neg <= neg[c] ^ neg[3];
			// A quotient of 2^32 or more saturates whatever its sign.
			lane_s3[c].ovf <= ACC_W'(hi[c]) >= ACC_W'(mag[3]);
			lane_s3[c].rem <= MAG_W'(hi[c]);
			lane_s3[c].low <= num[c][31:0];
			zres_s3[c] <= sat32(neg[c], mag[c] >> FRAC_BITS);
		end
	end
endmodule

### rtl/vtpd_div_lane.sv
`timescale 1ns / 1ps
module vtpd_div_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  vtpd_pkg::div_in_t          din,
	input  logic [vtpd_pkg::MAG_W-1:0] divisor,
	output logic                       out_valid,
	output logic [31:0]                quo,
	output logic                       neg,
	output logic                       ovf
);
	import vtpd_pkg::*;

	logic             vld_s [DIV_STAGES+1];
	logic [MAG_W-1:0] rem_s [DIV_STAGES+1];
	logic [31:0]      shf_s [DIV_STAGES+1];
	logic [MAG_W-1:0] d_s [DIV_STAGES+1];
	logic             neg_s [DIV_STAGES+1];
	logic             ovf_s [DIV_STAGES+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = din.rem;
	assign shf_s[0] = din.low;
	assign d_s[0] = divisor;
	assign neg_s[0] = din.neg;
	assign ovf_s[0] = din.ovf;

	// Numerator bits shift out of the top of shf while quotient bits enter at the bottom.
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [MAG_W-1:0] rem_n;
		logic [31:0]      shf_n;

		always_comb begin
			logic [MAG_W:0] t;
			logic           ge;
			rem_n = rem_s[g];
			shf_n = shf_s[g];
			for (int k = 0; k < STEPS_PER_STAGE; k++) begin
				t = {rem_n, shf_n[31]};
				ge = t >= {1'b0, d_s[g]};
				rem_n = ge ? MAG_W'(t - {1'b0, d_s[g]}) : t[MAG_W-1:0];
				shf_n = {shf_n[30:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[g+1] <= 1'b0;
			else vld_s[g+1] <= vld_s[g];
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= rem_n;
			shf_s[g+1] <= shf_n;
			d_s[g+1] <= d_s[g];
			neg_s[g+1] <= neg_s[g];
			ovf_s[g+1] <= ovf_s[g];
		end
	end

	assign out_valid = vld_s[DIV_STAGES];
	assign quo = shf_s[DIV_STAGES];
	assign neg = neg_s[DIV_STAGES];
	assign ovf = ovf_s[DIV_STAGES];
endmodule

### rtl/vertex_transform_perspective_divide.sv
`timescale 1ns / 1ps
// Pipeline: three arithmetic stages, sixteen divider stages of two quotient bits each
// and one output register lie between an accepted start and the done strobe.
// Throughput: one point per cycle; busy is never raised and the receiver cannot stall.
// Reset: asynchronous, active low; clears the pipeline valid bits and loads the
// identity matrix into the configuration registers.
module vertex_transform_perspective_divide #(
	parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  vtpd_pkg::point_t            point,
	output logic                        done,
	output vtpd_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vtpd_pkg::ADDR_W-1:0] paddr,
	input  logic [vtpd_pkg::DATA_W-1:0] pwdata,
	output logic [vtpd_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import vtpd_pkg::*;

	localparam int LATENCY = DIV_STAGES + 4;

	matrix_t          matrix;
	logic             valid_s3, wzero_s3;
	div_in_t          lane_s3 [LANES];
	sat_t             zres_s3 [LANES];
	logic [MAG_W-1:0] wmag_s3;

	logic        lane_valid [LANES];
	logic [31:0] lane_quo [LANES];
	logic        lane_neg [LANES];
	logic        lane_ovf [LANES];

	logic        wz_s [DIV_STAGES];
	sat_t        zres_s [DIV_STAGES][LANES];
	sat_t        fin [LANES];
	logic        done_q;
	result_t     result_q;

	assign busy = 1'b0;

	vtpd_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .matrix(matrix)
	);

	vtpd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy), .point(point),
		.matrix(matrix), .valid_s3(valid_s3), .lane_s3(lane_s3), .zres_s3(zres_s3),
		.wmag_s3(wmag_s3), .wzero_s3(wzero_s3)
	);

	for (genvar c = 0; c < LANES; c++) begin : g_lane
		vtpd_div_lane u_div (
			.clk(clk), .arst_n(arst_n), .in_valid(valid_s3), .din(lane_s3[c]),
			.divisor(wmag_s3), .out_valid(lane_valid[c]), .quo(lane_quo[c]),
			.neg(lane_neg[c]), .ovf(lane_ovf[c])
		);
	end

	// The undivided results and the zero flag ride alongside the divider.
	always_ff @(posedge clk) begin
		wz_s[0] <= wzero_s3;
		zres_s[0] <= zres_s3;
		for (int k = 1; k < DIV_STAGES; k++) begin
			wz_s[k] <= wz_s[k-1];
			zres_s[k] <= zres_s[k-1];
		end
	end

	always_comb begin
		for (int c = 0; c < LANES; c++) begin
			if (wz_s[DIV_STAGES-1]) begin
				fin[c] = zres_s[DIV_STAGES-1][c];
			end else if (lane_ovf[c]) begin
				fin[c].val = lane_neg[c] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				fin[c].clamp = 1'b1;
			end else begin
				fin[c] = sat32(lane_neg[c], MAG_W'(lane_quo[c]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= lane_valid[0];
	end

	always_ff @(posedge clk) begin
		result_q.out_x <= fin[0].val;
		result_q.out_y <= fin[1].val;
		result_q.out_z <= fin[2].val;
		result_q.w_was_zero <= wz_s[DIV_STAGES-1];
		result_q.saturated <= fin[0].clamp | fin[1].clamp | fin[2].clamp;
	end

	assign done = done_q;
	assign result = result_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("transaction did not complete at the expected latency");

	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lane_valid[0] == lane_valid[1] && lane_valid[1] == lane_valid[2])
		else $error("divider lanes out of step");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(lane_valid[0]))
		else $error("done raised without a divider result");
endmodule

### bench/vertex_transform_perspective_divide_test.sv
`timescale 1ns / 1ps
module vertex_transform_perspective_divide_test;
	import vtpd_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 30;
	localparam int POINTS_PER_MATRIX = 100;
	localparam int POINTS_PER_MODE = 600;

	typedef logic [DATA_W-1:0] reg_set_t [NUM_REGS];

	typedef enum {
		MAT_IDENTITY, MAT_W_ZERO, MAT_W_NEGATIVE, MAT_ALL_MAX, MAT_ALL_MIN, MAT_ALL_ONES
	} matrix_sel_e;

	typedef struct {
		matrix_sel_e sel;
		point_t      pt;
		bit          typed;
		result_t     want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	point_t point = '0;
	logic done;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	logic signed [31:0] coef [NUM_ENTRIES];
	result_t pending_results [$];
	int error_count = 0;
	int quiet_cycles = 0;
	int sender_idle_pct = 0;
	stim_row_t directed_rows [$];

	vertex_transform_perspective_divide DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Fixed-point transform followed by the perspective divide, done at 128 bits.
	function automatic result_t transform_point(point_t p);
		logic signed [127:0] acc [4];
		logic signed [127:0] px, py, pz;
		logic [127:0] wmag, mag, q;
		logic wzero, wneg, neg, rneg, clamp;
		logic [31:0] lane [3];
		result_t r;
		px = p.point_x;
		py = p.point_y;
		pz = p.point_z;
		clamp = 1'b0;
		for (int row = 0; row < 4; row++) begin
			acc[row] = px * 128'(coef[row]) + py * 128'(coef[4 + row])
				+ pz * 128'(coef[8 + row]) + (128'(coef[12 + row]) <<< FRAC_BITS_DEF);
		end
		wzero = (acc[3] == 0);
		wneg = acc[3] < 0;
		wmag = wneg ? -acc[3] : acc[3];
		for (int c = 0; c < 3; c++) begin
			neg = acc[c] < 0;
			mag = neg ? -acc[c] : acc[c];
			if (wzero) begin
				q = mag >> FRAC_BITS_DEF;
				rneg = neg;
			end else begin
				q = (mag << FRAC_BITS_DEF) / wmag;
				rneg = neg ^ wneg;
			end
			if (!rneg) begin
				if (q > 128'h7FFF_FFFF) begin
					lane[c] = 32'h7FFF_FFFF;
					clamp = 1'b1;
				end else begin
					lane[c] = q[31:0];
				end
			end else if (q > 128'h8000_0000) begin
				lane[c] = 32'h8000_0000;
				clamp = 1'b1;
			end else begin
				lane[c] = -q[31:0];
			end
		end
		r.out_x = lane[0];
		r.out_y = lane[1];
		r.out_z = lane[2];
		r.w_was_zero = wzero;
		r.saturated = clamp;
		return r;
	endfunction

	function automatic reg_set_t matrix_for(matrix_sel_e sel);
		reg_set_t m;
		m = '{default: '0};
		m[0] = 64'h1_0000;
		m[2] = 64'h1_0000 << 32;
		m[5] = 64'h1_0000;
		m[7] = 64'h1_0000 << 32;
		case (sel)
			MAT_W_ZERO: m[7] = '0;
			MAT_W_NEGATIVE: m[7] = 64'hFFFF_0000_0000_0000;
			MAT_ALL_MAX: m = '{default: 64'h7FFF_FFFF_7FFF_FFFF};
			MAT_ALL_MIN: m = '{default: 64'h8000_0000_8000_0000};
			MAT_ALL_ONES: m = '{default: '1};
			default: ;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] random_entry(bit small_only);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick < 3 && !small_only)
			return $urandom;
		// Mostly within plus or minus 4.0 so that divides give useful quotients.
		return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
	endfunction

	function automatic reg_set_t random_matrix();
		logic [31:0] e [NUM_ENTRIES];
		reg_set_t m;
		bit w_zero;
		w_zero = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			e[i] = random_entry(i % 4 == 3);
			if (w_zero && i % 4 == 3)
				e[i] = '0;
		end
		for (int k = 0; k < NUM_REGS; k++)
			m[k] = {e[2 * k + 1], e[2 * k]};
		return m;
	endfunction

	function automatic point_t random_point();
		point_t p;
		if ($urandom_range(0, 9) < 4) begin
			p.point_x = $urandom;
			p.point_y = $urandom;
			p.point_z = $urandom;
		end else begin
			p.point_x = 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
			p.point_y = 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
			p.point_z = 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
		end
		return p;
	endfunction

	// Registers may only change once the pipeline has emptied.
	task automatic load_matrix(reg_set_t m);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		for (int k = 0; k < NUM_REGS; k++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= ADDR_W'(8 * k);
			pwdata <= m[k];
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			coef[2 * k] = m[k][31:0];
			coef[2 * k + 1] = m[k][63:32];
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_point(point_t p, bit typed, result_t want);
		start <= 1'b1;
		point <= p;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(typed ? want : transform_point(p));
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected");
				error_count++;
			end else begin
				result_t want;
				want = pending_results.pop_front();
				if (result.out_x !== want.out_x) begin
					$error("out_x: expected %h, got %h", want.out_x, result.out_x);
					error_count++;
				end
				if (result.out_y !== want.out_y) begin
					$error("out_y: expected %h, got %h", want.out_y, result.out_y);
					error_count++;
				end
				if (result.out_z !== want.out_z) begin
					$error("out_z: expected %h, got %h", want.out_z, result.out_z);
					error_count++;
				end
				if (result.w_was_zero !== want.w_was_zero) begin
					$error("w_was_zero: expected %b, got %b", want.w_was_zero,
						result.w_was_zero);
					error_count++;
				end
				if (result.saturated !== want.saturated) begin
					$error("saturated: expected %b, got %b", want.saturated,
						result.saturated);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		matrix_sel_e current;
		result_t none;
		reg_set_t start_set;
		none = '0;
		start_set = matrix_for(MAT_IDENTITY);
		for (int k = 0; k < NUM_REGS; k++) begin
			coef[2 * k] = start_set[k][31:0];
			coef[2 * k + 1] = start_set[k][63:32];
		end
		// The identity passes points through unchanged; with w forced to zero the
		// points still come back unchanged but flagged.
		directed_rows.push_back('{MAT_IDENTITY, '{32'h0, 32'h0, 32'h0}, 1'b1,
			'{32'h0, 32'h0, 32'h0, 1'b0, 1'b0}});
		directed_rows.push_back('{MAT_IDENTITY, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1},
			1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1'b0, 1'b0}});
		directed_rows.push_back('{MAT_IDENTITY, '{32'h8000_0000, 32'h7FFF_FFFF, '1},
			1'b1, '{32'h8000_0000, 32'h7FFF_FFFF, '1, 1'b0, 1'b0}});
		directed_rows.push_back('{MAT_IDENTITY, '{32'h1_0000, 32'hFFFF_0000, 32'h8000},
			1'b1, '{32'h1_0000, 32'hFFFF_0000, 32'h8000, 1'b0, 1'b0}});
		directed_rows.push_back('{MAT_W_ZERO, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0},
			1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1, 1'b0}});
		directed_rows.push_back('{MAT_W_ZERO, '{'1, 32'h1_0000, 32'h5555_AAAA},
			1'b1, '{'1, 32'h1_0000, 32'h5555_AAAA, 1'b1, 1'b0}});
		directed_rows.push_back('{MAT_W_NEGATIVE, '{32'h3_0000, 32'hFFFD_0000, 32'h8000_0000},
			1'b0, none});
		directed_rows.push_back('{MAT_W_NEGATIVE, '{32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF},
			1'b0, none});
		directed_rows.push_back('{MAT_ALL_MAX, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
			1'b0, none});
		directed_rows.push_back('{MAT_ALL_MAX, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			1'b0, none});
		directed_rows.push_back('{MAT_ALL_MAX, '{32'h8000_0000, 32'h0, 32'h0}, 1'b0, none});
		directed_rows.push_back('{MAT_ALL_MIN, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0},
			1'b0, none});
		directed_rows.push_back('{MAT_ALL_MIN, '{32'h0, 32'h0, 32'h0}, 1'b0, none});
		directed_rows.push_back('{MAT_ALL_ONES, '{32'h1234_5678, 32'h8765_4321, 32'hFFFF},
			1'b0, none});
		directed_rows.push_back('{MAT_ALL_ONES, '{32'h0, 32'h0, 32'h0}, 1'b0, none});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		current = MAT_IDENTITY;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].sel != current) begin
				current = directed_rows[i].sel;
				load_matrix(matrix_for(current));
			end
			send_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].want);
		end

		for (int mode = 0; mode < 3; mode++) begin
			sender_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 59 : 0;
			for (int n = 0; n < POINTS_PER_MODE; n++) begin
				if (n % POINTS_PER_MATRIX == 0)
					load_matrix(random_matrix());
				send_point(random_point(), 1'b0, none);
			end
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

### vertex_transform_perspective_divide.f
rtl/vtpd_pkg.sv
rtl/vtpd_cfg.sv
rtl/vtpd_mac.sv
rtl/vtpd_div_lane.sv
rtl/vertex_transform_perspective_divide.sv
bench/vertex_transform_perspective_divide_test.sv
